// ===== design/dqs_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the double-ended queue with search.
// No dependencies; used by dqs_cell and double_ended_queue_with_search_top.
package dqs_pkg;

    localparam int DATA_W       = 32;
    localparam int ACT_W        = 3;
    localparam int ST_W         = 2;
    localparam int CAPACITY_DEF = 16;

    localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_SEARCH     = 3'd4;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    // Broadcast from the controller to every cell of the row
    typedef struct packed {
        logic                     shift_in;   // push front: take left neighbour
        logic                     shift_out;  // pop front: take right neighbour
        logic                     load;       // push back: cell at occupancy loads value
        logic                     cmp;        // search: register a match flag
        logic signed [DATA_W-1:0] value;
    } cell_ctrl_t;

endpackage

// ===== design/dqs_cell.sv =====
`timescale 1ns / 1ps
// One storage cell of the queue row: holds one entry, shifts with its neighbours.
// Depends on dqs_pkg.
module dqs_cell
    import dqs_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
)
(
    input  logic                     clk,
    input  cell_ctrl_t               ctrl,
    input  logic [CNT_W-1:0]         occ,
    input  logic signed [DATA_W-1:0] left_data,
    input  logic signed [DATA_W-1:0] right_data,
    output logic signed [DATA_W-1:0] data,
    output logic                     hit,
    output logic signed [DATA_W-1:0] tail_data
);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic                     hit_reg;
    logic                     hit_next;
    logic                     held;
    logic                     is_tail;
    logic                     is_free_head;

    // cell i is held when i < occupancy; entries live at 0 .. occupancy-1
    assign held         = (CNT_W'(IDX) < occ);
    assign is_tail      = (occ == CNT_W'(IDX + 1));
    assign is_free_head = (occ == CNT_W'(IDX));

    always_comb
    begin
        data_next = data_reg;
        hit_next  = hit_reg;
        if (ctrl.shift_in)
        begin
            data_next = left_data;
        end
        else if (ctrl.shift_out)
        begin
            data_next = right_data;
        end
        else if (ctrl.load && is_free_head)
        begin
            data_next = ctrl.value;
        end
        if (ctrl.cmp)
        begin
            hit_next = held && (data_reg == ctrl.value);
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        hit_reg  <= hit_next;
    end

    assign data      = data_reg;
    assign hit       = hit_reg;
    assign tail_data = is_tail ? data_reg : '0;

endmodule

// ===== design/double_ended_queue_with_search_top.sv =====
`timescale 1ns / 1ps
// Top level of the double-ended queue with membership search.
// Depends on dqs_pkg and dqs_cell.
//
// A request is taken when start is high and busy is low. For pushes, pops and
// unused action codes, done strobes for one cycle on the clock after the
// request with the result on the output ports. In a search, every cell first
// registers its own compare, then the match flags are ORed across the row;
// busy is high for the one cycle in between. Entries sit in a row of CAPACITY
// cells with the front in cell 0, so a push or pop at the front shifts the
// whole row by one place. The receiver cannot stall: each result is shown for
// exactly one cycle and must be taken then.
module double_ended_queue_with_search_top
    import dqs_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [ACT_W-1:0]         action,
    input  logic signed [DATA_W-1:0] value,
    output logic                     done,
    output logic signed [DATA_W-1:0] popped_value,
    output logic                     found,
    output logic [ST_W-1:0]          status,
    output logic                     now_empty
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]         occ_reg;
    logic [CNT_W-1:0]         occ_next;
    logic                     srch_pend_reg;
    logic                     srch_pend_next;
    logic                     done_reg;
    logic                     done_next;
    logic signed [DATA_W-1:0] popped_reg;
    logic signed [DATA_W-1:0] popped_next;
    logic                     found_reg;
    logic                     found_next;
    logic [ST_W-1:0]          status_reg;
    logic [ST_W-1:0]          status_next;
    logic                     empty_reg;
    logic                     empty_next;

    cell_ctrl_t               ctrl;
    logic                     accept;
    logic                     full;
    logic                     empty;
    logic signed [DATA_W-1:0] data_vec [CAPACITY];
    logic signed [DATA_W-1:0] tail_vec [CAPACITY];
    logic [CAPACITY-1:0]      hit_vec;
    logic signed [DATA_W-1:0] tail_or;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic signed [DATA_W-1:0] left_d;
            logic signed [DATA_W-1:0] right_d;
            if (g == 0)
            begin : g_first
                assign left_d = value;
            end
            else
            begin : g_mid_l
                assign left_d = data_vec[g-1];
            end
            if (g == CAPACITY - 1)
            begin : g_last
                assign right_d = '0;
            end
            else
            begin : g_mid_r
                assign right_d = data_vec[g+1];
            end

            dqs_cell #(
                .IDX   (g),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .occ        (occ_reg),
                .left_data  (left_d),
                .right_data (right_d),
                .data       (data_vec[g]),
                .hit        (hit_vec[g]),
                .tail_data  (tail_vec[g])
            );
        end
    endgenerate

    // only the tail cell drives a non-zero word
    always_comb
    begin
        tail_or = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            tail_or = tail_or | tail_vec[i];
        end
    end

    assign accept = start && !busy;
    assign full   = (occ_reg == CNT_W'(CAPACITY));
    assign empty  = (occ_reg == '0);

    always_comb
    begin
        ctrl           = '0;
        ctrl.value     = value;
        occ_next       = occ_reg;
        srch_pend_next = 1'b0;
        done_next      = 1'b0;
        popped_next    = '0;
        found_next     = 1'b0;
        status_next    = ST_OK;

        if (srch_pend_reg)
        begin
            done_next  = 1'b1;
            found_next = |hit_vec;
        end
        else if (accept)
        begin
            done_next = 1'b1;
            case (action)
                ACT_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        ctrl.shift_in = 1'b1;
                        occ_next      = occ_reg + 1'b1;
                    end
                end
                ACT_PUSH_BACK:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        ctrl.load = 1'b1;
                        occ_next  = occ_reg + 1'b1;
                    end
                end
                ACT_POP_FRONT:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        popped_next    = data_vec[0];
                        ctrl.shift_out = 1'b1;
                        occ_next       = occ_reg - 1'b1;
                    end
                end
                ACT_POP_BACK:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        popped_next = tail_or;
                        occ_next    = occ_reg - 1'b1;
                    end
                end
                ACT_SEARCH:
                begin
                    ctrl.cmp       = 1'b1;
                    srch_pend_next = 1'b1;
                    done_next      = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
        empty_next = (occ_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            srch_pend_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            occ_reg       <= occ_next;
            srch_pend_reg <= srch_pend_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        popped_reg <= popped_next;
        found_reg  <= found_next;
        status_reg <= status_next;
        empty_reg  <= empty_next;
    end

    assign busy         = srch_pend_reg;
    assign done         = done_reg;
    assign popped_value = popped_reg;
    assign found        = found_reg;
    assign status       = status_reg;
    assign now_empty    = empty_reg;

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_W'(CAPACITY))
        else $error("occupancy beyond capacity");

    a_search_done: assert property (@(posedge clk) disable iff (!rst_n)
        srch_pend_reg |=> done && !busy)
        else $error("search result not delivered after compare cycle");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (now_empty == (occ_reg == '0)))
        else $error("now_empty disagrees with occupancy");

    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == ST_EMPTY) |-> (popped_value == '0) && !found)
        else $error("pop on empty queue returned data");

    a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && full
            && ((action == ACT_PUSH_FRONT) || (action == ACT_PUSH_BACK))
        |=> done && (status == ST_FULL) && (occ_reg == $past(occ_reg)))
        else $error("push into full queue not dropped");

endmodule

// ===== dv/tb_double_ended_queue_with_search_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the double-ended queue with search: a directed
// opening, then random push/pop/search bursts against an in-bench deque model.
// Depends on dqs_pkg and double_ended_queue_with_search_top.
module tb_double_ended_queue_with_search_top;
    import dqs_pkg::*;

    localparam int CAP          = CAPACITY_DEF;
    localparam int N_RANDOM     = 1330;
    localparam int PHASE_LEN    = 450;
    localparam int STALL_LIMIT  = 2000;
    localparam int MAX_REPORTS  = 10;

    // action codes the block must treat as no-ops
    localparam logic [ACT_W-1:0] ACT_SPARE_FIRST = 3'd5;
    localparam logic [ACT_W-1:0] ACT_SPARE_LAST  = 3'd7;

    typedef struct {
        logic [ACT_W-1:0]         act;
        logic signed [DATA_W-1:0] val;
    } deque_request_t;

    typedef struct {
        logic signed [DATA_W-1:0] popped;
        logic                     found;
        logic [ST_W-1:0]          status;
        logic                     now_empty;
    } deque_result_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic [ACT_W-1:0]         action = ACT_PUSH_FRONT;
    logic signed [DATA_W-1:0] value = '0;
    logic                     busy;
    logic                     done;
    logic signed [DATA_W-1:0] popped_value;
    logic                     found;
    logic [ST_W-1:0]          status;
    logic                     now_empty;

    double_ended_queue_with_search_top #(
        .CAPACITY (CAP)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .value        (value),
        .done         (done),
        .popped_value (popped_value),
        .found        (found),
        .status       (status),
        .now_empty    (now_empty)
    );

    deque_request_t           pending_requests[$];
    deque_result_t            expected_results[$];
    logic signed [DATA_W-1:0] value_pool[8];

    // deque model state
    logic signed [DATA_W-1:0] held[CAP];
    int                       head_idx = 0;
    int                       fill = 0;

    int n_accepted = 0;
    int n_checked = 0;
    int n_mismatch = 0;
    int n_full_drops = 0;
    int n_empty_pops = 0;
    int n_search_hits = 0;
    int n_spare = 0;
    int idle_cycles = 0;

    // Applies one request to the model and returns the result it should give
    function automatic deque_result_t apply_request(logic [ACT_W-1:0] act,
                                                    logic signed [DATA_W-1:0] val);
        deque_result_t r;
        r.popped = '0;
        r.found = 1'b0;
        r.status = ST_OK;
        r.now_empty = 1'b0;
        case (act)
            ACT_PUSH_FRONT, ACT_PUSH_BACK:
            begin
                if (fill == CAP)
                begin
                    r.status = ST_FULL;
                    n_full_drops++;
                end
                else if (act == ACT_PUSH_FRONT)
                begin
                    head_idx = (head_idx == 0) ? CAP - 1 : head_idx - 1;
                    held[head_idx] = val;
                    fill++;
                end
                else
                begin
                    held[(head_idx + fill) % CAP] = val;
                    fill++;
                end
            end
            ACT_POP_FRONT, ACT_POP_BACK:
            begin
                if (fill == 0)
                begin
                    r.status = ST_EMPTY;
                    n_empty_pops++;
                end
                else if (act == ACT_POP_FRONT)
                begin
                    r.popped = held[head_idx];
                    head_idx = (head_idx + 1) % CAP;
                    fill--;
                end
                else
                begin
                    r.popped = held[(head_idx + fill - 1) % CAP];
                    fill--;
                end
            end
            ACT_SEARCH:
            begin
                for (int i = 0; i < fill; i++)
                    if (held[(head_idx + i) % CAP] == val)
                        r.found = 1'b1;
                if (r.found)
                    n_search_hits++;
            end
            default:
                n_spare++;
        endcase
        r.now_empty = (fill == 0);
        return r;
    endfunction

    task automatic queue_request(logic [ACT_W-1:0] act, logic signed [DATA_W-1:0] val);
        deque_request_t req;
        req.act = act;
        req.val = val;
        pending_requests.push_back(req);
    endtask

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Request stream: directed opening, then bursts biased to fill, drain or mix
    initial
    begin
        int mode;
        int burst;
        int n_random;
        int pick;
        logic [ACT_W-1:0] act;
        logic signed [DATA_W-1:0] val;

        value_pool[0] = 32'sh8000_0000;
        value_pool[1] = 32'sh7FFF_FFFF;
        value_pool[2] = '0;
        value_pool[3] = -32'sd1;
        for (int i = 4; i < 8; i++)
            value_pool[i] = $urandom;

        queue_request(ACT_POP_FRONT, 32'sd5);
        queue_request(ACT_POP_BACK, -32'sd1);
        queue_request(ACT_SEARCH, '0);
        queue_request(ACT_PUSH_FRONT, 32'sh7FFF_FFFF);
        queue_request(ACT_PUSH_BACK, 32'sh8000_0000);
        queue_request(ACT_PUSH_FRONT, -32'sd1);
        queue_request(ACT_PUSH_BACK, '0);
        queue_request(ACT_SEARCH, 32'sh7FFF_FFFF);
        queue_request(ACT_SEARCH, 32'sh8000_0000);
        queue_request(ACT_SEARCH, 32'sd1);
        for (int a = ACT_SPARE_FIRST; a <= ACT_SPARE_LAST; a++)
            queue_request(ACT_W'(a), -32'sd1);
        queue_request(ACT_POP_FRONT, '0);
        queue_request(ACT_POP_BACK, '0);
        queue_request(ACT_POP_BACK, '0);
        queue_request(ACT_POP_FRONT, '0);
        queue_request(ACT_POP_FRONT, '0);
        queue_request(ACT_SEARCH, '0);

        n_random = 0;
        while (n_random < N_RANDOM)
        begin
            mode = $urandom_range(0, 2);
            burst = $urandom_range(4, 40);
            for (int k = 0; k < burst; k++)
            begin
                pick = $urandom_range(0, 99);
                case (mode)
                    0: act = (pick < 80)
                           ? ($urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT)
                           : (pick < 92) ? ACT_SEARCH
                           : ($urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT);
                    1: act = (pick < 80)
                           ? ($urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT)
                           : (pick < 92) ? ACT_SEARCH
                           : ($urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT);
                    default: act = ACT_W'($urandom_range(0, 7));
                endcase
                // reuse a small pool so searches often hit
                val = $urandom_range(0, 99) < 60 ? value_pool[$urandom_range(0, 7)] : $urandom;
                queue_request(act, val);
                n_random++;
            end
        end
    end

    // Driver: one request at a time, held until start && !busy at an edge
    always @(posedge clk or negedge rst_n)
    begin
        deque_request_t req;
        logic           took;
        logic           pause;
        if (!rst_n)
        begin
            start <= 1'b0;
            action <= ACT_PUSH_FRONT;
            value <= '0;
        end
        else
        begin
            took = start && !busy;
            if (took)
            begin
                expected_results.push_back(apply_request(action, value));
                n_accepted++;
            end
            if (!start || took)
            begin
                if (n_accepted < PHASE_LEN)
                    pause = $urandom_range(0, 99) < 9;
                else if (n_accepted < 2 * PHASE_LEN)
                    pause = $urandom_range(0, 99) < 75;
                else
                    pause = 1'b0;
                if (pending_requests.size() > 0 && !pause)
                begin
                    req = pending_requests.pop_front();
                    start <= 1'b1;
                    action <= req.act;
                    value <= req.val;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Monitor: every done strobe is checked against the oldest expectation
    always @(posedge clk)
    begin
        deque_result_t e;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                if (n_mismatch < MAX_REPORTS)
                    $display({"[%0t] result with nothing outstanding: ",
                              "popped=%0d found=%0b status=%0d empty=%0b"},
                             $time, popped_value, found, status, now_empty);
                n_mismatch++;
            end
            else
            begin
                e = expected_results.pop_front();
                n_checked++;
                if (popped_value !== e.popped || found !== e.found ||
                    status !== e.status || now_empty !== e.now_empty)
                begin
                    if (n_mismatch < MAX_REPORTS)
                        $display({"[%0t] mismatch on result %0d: ",
                                  "exp popped=%0d found=%0b status=%0d empty=%0b, ",
                                  "got popped=%0d found=%0b status=%0d empty=%0b"},
                                 $time, n_checked, e.popped, e.found, e.status,
                                 e.now_empty, popped_value, found, status, now_empty);
                    n_mismatch++;
                end
            end
        end
    end

    // Watchdog: cycles with neither a request taken nor a result shown
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("[%0t] no progress for %0d cycles", $time, STALL_LIMIT);
                $display("double_ended_queue_with_search_top test failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        @(posedge rst_n);
        do
            @(negedge clk);
        while (pending_requests.size() > 0 || start || expected_results.size() > 0);
        repeat (4) @(negedge clk);
        $display("%0d requests taken, %0d results checked, %0d mismatches",
                 n_accepted, n_checked, n_mismatch);
        $display("full-queue drops %0d, empty pops %0d, search hits %0d, spare codes %0d",
                 n_full_drops, n_empty_pops, n_search_hits, n_spare);
        if (n_mismatch == 0 && expected_results.size() == 0)
            $display("double_ended_queue_with_search_top test passed");
        else
            $display("double_ended_queue_with_search_top test failed");
        $finish;
    end

endmodule
